// ----- rtl/xxt_pkg.sv -----
// Shared constants, types and arithmetic helpers of the XXTEA engine.
`timescale 1ns / 1ps

package xxt_pkg;

    localparam int XXT_MAX_WORDS = 64;
    localparam int XXT_WORD_W    = 32;
    localparam int XXT_ROUND_W   = 6;
    localparam int XXT_KEY_WORDS = 4;
    localparam int XXT_ADDR_W    = 4;

    localparam logic [XXT_WORD_W-1:0] XXT_DELTA = 32'h9E3779B9;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP0,
        S_PREP1,
        S_PREP2,
        S_RUN,
        S_EMIT
    } xxt_state_t;

    typedef logic [XXT_KEY_WORDS-1:0][XXT_WORD_W-1:0] xxt_key_t;

    // Full mixing rounds for a block of n words: 6 + 52 / n, as a range table.
    function automatic logic [XXT_ROUND_W-1:0] xxt_rounds(input int unsigned n);
        logic [XXT_ROUND_W-1:0] extra;
        if (n <= 2)
            extra = 6'd26;
        else if (n == 3)
            extra = 6'd17;
        else if (n == 4)
            extra = 6'd13;
        else if (n == 5)
            extra = 6'd10;
        else if (n == 6)
            extra = 6'd8;
        else if (n == 7)
            extra = 6'd7;
        else if (n == 8)
            extra = 6'd6;
        else if (n <= 10)
            extra = 6'd5;
        else if (n <= 13)
            extra = 6'd4;
        else if (n <= 17)
            extra = 6'd3;
        else if (n <= 26)
            extra = 6'd2;
        else if (n <= 52)
            extra = 6'd1;
        else
            extra = 6'd0;
        return 6'd6 + extra;
    endfunction

    // The MX mixing function of corrected Block TEA.
    function automatic logic [XXT_WORD_W-1:0] xxt_mx(
        input logic [XXT_WORD_W-1:0] y,
        input logic [XXT_WORD_W-1:0] z,
        input logic [XXT_WORD_W-1:0] sum,
        input logic [XXT_WORD_W-1:0] k
    );
        logic [XXT_WORD_W-1:0] a;
        logic [XXT_WORD_W-1:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (k ^ z);
        return a ^ b;
    endfunction

endpackage

// ----- rtl/xxt_word_if.sv -----
// Input channel carrying one block word per transaction.
`timescale 1ns / 1ps

interface xxt_word_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] data_word;
    logic        last;

    modport source (output valid, output command, output data_word, output last,
                    input ready);
    modport sink   (input valid, input command, input data_word, input last,
                    output ready);
endinterface

// ----- rtl/xxt_result_if.sv -----
// Output channel carrying one processed word per transaction.
`timescale 1ns / 1ps

interface xxt_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_word;
    logic        result_last;
    logic        error;

    modport source (output valid, output result_word, output result_last,
                    output error, input ready);
    modport sink   (input valid, input result_word, input result_last,
                    input error, output ready);
endinterface

// ----- rtl/xxt_regs.sv -----
// APB register file holding the four cipher key words.
`timescale 1ns / 1ps

module xxt_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [xxt_pkg::XXT_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output xxt_pkg::xxt_key_t              key
);
    import xxt_pkg::*;

    xxt_key_t        key_reg;
    logic [1:0]      reg_idx;

    assign reg_idx = paddr[XXT_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = key_reg[reg_idx];
    assign key     = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            key_reg[reg_idx] <= pwdata;
        end
    end

endmodule

// ----- rtl/xxt_store.sv -----
// Block word memory with a registered read port and write-to-read forwarding.
`timescale 1ns / 1ps

module xxt_store #(
    parameter int MAX_WORDS = xxt_pkg::XXT_MAX_WORDS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         we,
    input  logic [$clog2(MAX_WORDS)-1:0] waddr,
    input  logic [31:0]                  wdata,
    input  logic [$clog2(MAX_WORDS)-1:0] raddr,
    output logic [31:0]                  rdata
);
    import xxt_pkg::*;

    logic [XXT_WORD_W-1:0] mem [MAX_WORDS];
    logic [XXT_WORD_W-1:0] q_reg;
    logic [XXT_WORD_W-1:0] fwd_data_reg;
    logic                  fwd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg        <= mem[raddr];
        fwd_data_reg <= wdata;
    end

    // A read that meets a write to the same entry returns the new word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = fwd_reg ? fwd_data_reg : q_reg;

endmodule

// ----- rtl/xxt_ctrl.sv -----
// Sequencer and mixing datapath: block load, cipher rounds and word emission.
`timescale 1ns / 1ps

module xxt_ctrl #(
    parameter int MAX_WORDS = xxt_pkg::XXT_MAX_WORDS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  xxt_pkg::xxt_key_t            key,
    xxt_word_if.sink                     word_chan,
    xxt_result_if.source                 result_chan,
    output logic                         mem_we,
    output logic [$clog2(MAX_WORDS)-1:0] mem_waddr,
    output logic [31:0]                  mem_wdata,
    output logic [$clog2(MAX_WORDS)-1:0] mem_raddr,
    input  logic [31:0]                  mem_rdata
);
    import xxt_pkg::*;

    localparam int AW = $clog2(MAX_WORDS);
    localparam int CW = $clog2(MAX_WORDS + 1);

    xxt_state_t state_reg, state_next;

    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          n_reg, n_next;
    logic                   cmd_reg, cmd_next;
    logic                   err_reg, err_next;
    logic [AW-1:0]          p_reg, p_next;
    logic [XXT_ROUND_W-1:0] rounds_reg, rounds_next;
    logic [XXT_WORD_W-1:0]  sum_reg, sum_next;
    logic [XXT_WORD_W-1:0]  x_reg, x_next;
    logic [XXT_WORD_W-1:0]  w_reg, w_next;
    logic [AW-1:0]          emit_idx_reg, emit_idx_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic [XXT_WORD_W-1:0]  out_word_reg, out_word_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_err_reg, out_err_next;

    logic                   accept;
    logic                   store_ok;
    logic [CW-1:0]          n_at_last;
    logic [AW-1:0]          last_idx;
    logic                   decrypt;
    logic                   round_end;
    logic                   run_done;
    logic                   slot_free;
    logic                   take;
    logic [1:0]             key_idx;
    logic [XXT_WORD_W-1:0]  mix_y;
    logic [XXT_WORD_W-1:0]  mix_z;
    logic [XXT_WORD_W-1:0]  mix_val;
    logic [XXT_WORD_W-1:0]  new_word;
    logic [AW-1:0]          p_step;

    // Next word index in processing order: ascending for encryption,
    // descending for decryption, wrapping at the block ends.
    function automatic logic [AW-1:0] step_idx(
        input logic [AW-1:0] p,
        input logic          dec,
        input logic [AW-1:0] lst
    );
        logic [AW-1:0] r;
        if (dec)
            r = (p == '0) ? lst : p - AW'(1);
        else
            r = (p == lst) ? '0 : p + AW'(1);
        return r;
    endfunction

    assign accept    = word_chan.valid && word_chan.ready;
    assign store_ok  = count_reg < CW'(MAX_WORDS);
    assign n_at_last = store_ok ? count_reg + CW'(1) : count_reg;
    assign last_idx  = AW'(n_reg - CW'(1));
    assign decrypt   = (cmd_reg == CMD_DECRYPT);
    assign round_end = decrypt ? (p_reg == '0) : (p_reg == last_idx);
    assign run_done  = round_end && (rounds_reg == XXT_ROUND_W'(1));
    assign slot_free = !out_valid_reg || result_chan.ready;
    assign take      = (state_reg == S_EMIT) && pend_reg && slot_free;

    // Encryption reads the word after p as y and carries z; decryption
    // reads the word before p as z and carries y.
    assign key_idx  = 2'(p_reg) ^ sum_reg[3:2];
    assign mix_y    = decrypt ? w_reg : mem_rdata;
    assign mix_z    = decrypt ? mem_rdata : w_reg;
    assign mix_val  = xxt_mx(mix_y, mix_z, sum_reg, key[key_idx]);
    assign new_word = decrypt ? x_reg - mix_val : x_reg + mix_val;
    assign p_step   = step_idx(p_reg, decrypt, last_idx);

    assign word_chan.ready     = (state_reg == S_IDLE);
    assign result_chan.valid   = out_valid_reg;
    assign result_chan.result_word = out_word_reg;
    assign result_chan.result_last = out_last_reg;
    assign result_chan.error   = out_err_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && word_chan.last)
                    state_next = (n_at_last < CW'(2)) ? S_EMIT : S_PREP0;
            end
            S_PREP0: state_next = S_PREP1;
            S_PREP1: state_next = S_PREP2;
            S_PREP2: state_next = S_RUN;
            S_RUN:
            begin
                if (run_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (take && (emit_idx_reg == last_idx))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        n_next        = n_reg;
        cmd_next      = cmd_reg;
        err_next      = err_reg;
        p_next        = p_reg;
        rounds_next   = rounds_reg;
        sum_next      = sum_reg;
        x_next        = x_reg;
        w_next        = w_reg;
        emit_idx_next = emit_idx_reg;
        pend_next     = pend_reg;
        out_word_next = out_word_reg;
        out_last_next = out_last_reg;
        out_err_next  = out_err_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = word_chan.data_word;
        mem_raddr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mem_we = store_ok;
                    if (word_chan.last)
                    begin
                        count_next    = '0;
                        n_next        = n_at_last;
                        cmd_next      = word_chan.command;
                        err_next      = (n_at_last < CW'(2));
                        emit_idx_next = '0;
                        pend_next     = 1'b0;
                    end
                    else if (store_ok)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            S_PREP0:
            begin
                mem_raddr   = decrypt ? last_idx : '0;
                rounds_next = xxt_rounds(32'(n_reg));
                p_next      = decrypt ? last_idx : '0;
            end
            S_PREP1:
            begin
                x_next    = mem_rdata;
                mem_raddr = decrypt ? '0 : last_idx;
                sum_next  = decrypt ?
                            XXT_DELTA * {{(XXT_WORD_W - XXT_ROUND_W){1'b0}}, rounds_reg} :
                            XXT_DELTA;
            end
            S_PREP2:
            begin
                w_next    = mem_rdata;
                mem_raddr = step_idx(p_reg, decrypt, last_idx);
            end
            S_RUN:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg;
                mem_wdata = new_word;
                x_next    = mem_rdata;
                w_next    = new_word;
                p_next    = p_step;
                mem_raddr = step_idx(p_step, decrypt, last_idx);
                if (round_end)
                begin
                    rounds_next = rounds_reg - XXT_ROUND_W'(1);
                    sum_next    = decrypt ? sum_reg - XXT_DELTA : sum_reg + XXT_DELTA;
                end
                if (run_done)
                begin
                    emit_idx_next = '0;
                    pend_next     = 1'b0;
                end
            end
            S_EMIT:
            begin
                mem_raddr = take ? emit_idx_reg + AW'(1) : emit_idx_reg;
                pend_next = 1'b1;
                if (take)
                begin
                    emit_idx_next = emit_idx_reg + AW'(1);
                    out_word_next = mem_rdata;
                    out_last_next = (emit_idx_reg == last_idx);
                    out_err_next  = err_reg;
                end
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase

        if (take)
            out_valid_next = 1'b1;
        else if (result_chan.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            cmd_reg       <= CMD_ENCRYPT;
            err_reg       <= 1'b0;
            p_reg         <= '0;
            rounds_reg    <= '0;
            sum_reg       <= '0;
            emit_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            cmd_reg       <= cmd_next;
            err_reg       <= err_next;
            p_reg         <= p_next;
            rounds_reg    <= rounds_next;
            sum_reg       <= sum_next;
            emit_idx_reg  <= emit_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        w_reg        <= w_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    // The round engine only runs on blocks of two or more words.
    a_run_block_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (n_reg >= CW'(2)))
        else $error("round engine running on a block shorter than two words");

    // While the round engine runs, at least one round is always left.
    a_run_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (rounds_reg != '0))
        else $error("round engine running with no rounds left");

    // Emission never walks past the end of the block.
    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emit_idx_reg <= last_idx))
        else $error("emission index beyond the block");

    // The word flagged last closes the block and the engine goes idle.
    a_emit_close: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (emit_idx_reg == last_idx)) |=> (state_reg == S_IDLE) && out_last_reg)
        else $error("final word emitted without closing the block");

endmodule

// ----- rtl/xxtea_block_cipher.sv -----
// Top level of the XXTEA block cipher engine: key registers, word store, sequencer.
// Load takes words only while idle. A block of n >= 2 words then passes the setup
// states PREP0, PREP1, PREP2 and runs 6 + 52/n rounds, one word update per cycle.
// Emission reads the first word, then delivers one word per cycle when not stalled.
// Reset (rst_n low, asynchronous) clears key and control state; store is not cleared.
`timescale 1ns / 1ps

module xxtea_block_cipher #(
    parameter int MAX_WORDS = xxt_pkg::XXT_MAX_WORDS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [xxt_pkg::XXT_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    xxt_word_if.sink                       word_chan,
    xxt_result_if.source                   result_chan
);
    import xxt_pkg::*;

    localparam int AW = $clog2(MAX_WORDS);

    // The user is to write the cipher key through the register port only while the
    // engine is idle, not enforced by the block; key word i lies at byte address 4*i.
    xxt_key_t              key;

    // Single-port-write, single-port-read store for the block words. The
    // sequencer writes incoming words during load, rewrites one word per cycle
    // during the rounds, and reads the words back out for emission.
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [XXT_WORD_W-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [XXT_WORD_W-1:0] mem_rdata;

    xxt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    xxt_store #(
        .MAX_WORDS (MAX_WORDS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The sequencer accepts words only while idle. Each round step reads the
    // neighbor word, mixes it with the word read on the previous step and the
    // word written on the previous step, and writes the result back; a read of
    // the entry being written in the same cycle is forwarded by the store.
    // Results pass through an output register, so the next block may start
    // loading while the final word of the previous block waits to be taken.
    xxt_ctrl #(
        .MAX_WORDS (MAX_WORDS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key),
        .word_chan   (word_chan),
        .result_chan (result_chan),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

endmodule
